/* rtl/core/lntf_pkg.sv */
// ----------------------------------------------------------------------------
// lntf_pkg
// Shared constants, types and the window offset table of the lidar nearest
// target finder.
// ----------------------------------------------------------------------------
package lntf_pkg;

  localparam int SCAN_POINTS = 360;
  localparam int HALF_WINDOW = 10;
  localparam int NUM_SLOTS   = 2 * HALF_WINDOW + 1;

  localparam int DIST_W      = 16;
  localparam int ANGLE_W     = $clog2(SCAN_POINTS);
  localparam int SIDX_W      = $clog2(NUM_SLOTS);
  localparam int SLOT_W      = 5;
  localparam int ANGLE_OUT_W = 9;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  // register indexes
  localparam logic REG_MAX_RANGE = 1'b0;
  localparam logic REG_SHAPE_TOL = 1'b1;

  localparam logic [DIST_W-1:0] MAX_RANGE_RST = 16'd3000;
  localparam logic [DIST_W-1:0] SHAPE_TOL_RST = 16'd50;

  typedef struct packed {
    logic [DIST_W-1:0] max_range;
    logic [DIST_W-1:0] shape_tol;
  } cfg_t;

  // end of scan summary, handed from the loader to the window pass
  typedef struct packed {
    logic               start;
    logic               found;
    logic [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]  nearest;
  } scan_done_t;

  // offset added to the target angle for a profile slot, before the wrap
  function automatic logic [ANGLE_W:0] slot_offset(input logic [SIDX_W-1:0] s);
    int k;
    logic [ANGLE_W:0] r;
    if (int'(s) > HALF_WINDOW) begin
      k = int'(s) - HALF_WINDOW;
    end else begin
      k = HALF_WINDOW - int'(s);
    end
    // offsets past a full turn wrap once
    if (k >= SCAN_POINTS) begin
      k = k - SCAN_POINTS;
    end
    if (int'(s) > HALF_WINDOW) begin
      r = (ANGLE_W+1)'(k);
    end else begin
      r = (ANGLE_W+1)'(SCAN_POINTS - k);
    end
    return r;
  endfunction

endpackage

/* rtl/core/lidar_nearest_target_finder_unit.sv */
// ----------------------------------------------------------------------------
// lidar_nearest_target_finder_unit
// Finds the nearest target in a lidar scan and reports its shape profile.
// ----------------------------------------------------------------------------
// A scan of 360 distances is taken one request per cycle, unless stalled, and
// kept in a 360 x 16 scan RAM while the nearest valid distance is tracked on
// the fly. The request that completes a scan starts the window pass: the
// target and its 20 neighbours are read from the RAM's single read port, one
// address a cycle, then the 21 profile results leave through a registered
// output at one per cycle while the output does not stall. The input is
// stalled from the end of a scan until the last result is loaded into the
// output register.
module lidar_nearest_target_finder_unit
  import lntf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [DIST_W-1:0]      in_distance,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [DIST_W-1:0]      out_shape_distance,
  output logic [ANGLE_OUT_W-1:0] out_target_angle,
  output logic [DIST_W-1:0]      out_nearest_distance,
  output logic [ANGLE_OUT_W-1:0] out_span_low_angle,
  output logic [ANGLE_OUT_W-1:0] out_span_high_angle,
  output logic                   out_found,
  output logic                   out_last,

  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t               cfg;
  scan_done_t         done;
  logic               busy;
  logic               ram_we;
  logic [ANGLE_W-1:0] ram_waddr;
  logic [DIST_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [ANGLE_W-1:0] ram_raddr;
  logic [DIST_W-1:0]  ram_rdata;

  assign in_stall = busy;

  lntf_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lntf_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_distance (in_distance),
    .busy        (busy),
    .cfg         (cfg),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .done        (done)
  );

  lntf_ram #(
    .WIDTH (DIST_W),
    .DEPTH (SCAN_POINTS)
  ) u_scan_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lntf_window u_window (
    .clk                  (clk),
    .rst_n                (rst_n),
    .done                 (done),
    .cfg                  (cfg),
    .busy                 (busy),
    .ram_re               (ram_re),
    .ram_raddr            (ram_raddr),
    .ram_rdata            (ram_rdata),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_slot             (out_slot),
    .out_shape_distance   (out_shape_distance),
    .out_target_angle     (out_target_angle),
    .out_nearest_distance (out_nearest_distance),
    .out_span_low_angle   (out_span_low_angle),
    .out_span_high_angle  (out_span_high_angle),
    .out_found            (out_found),
    .out_last             (out_last)
  );

endmodule

/* rtl/core/lntf_ram.sv */
// ----------------------------------------------------------------------------
// lntf_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lntf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 360
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/lntf_cfg.sv */
// ----------------------------------------------------------------------------
// lntf_cfg
// APB register bank: maximum target distance and shape distance limit.
// ----------------------------------------------------------------------------
module lntf_cfg
  import lntf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  logic [DIST_W-1:0] max_dist_r, max_dist_nxt;
  logic [DIST_W-1:0] lim_r, lim_nxt;
  logic              wr_en;
  logic              reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[2];

  always_comb begin
    max_dist_nxt = max_dist_r;
    lim_nxt      = lim_r;
    if (wr_en) begin
      case (reg_idx)
        REG_MAX_RANGE: max_dist_nxt = cfg_pwdata[DIST_W-1:0];
        REG_SHAPE_TOL: lim_nxt      = cfg_pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r <= MAX_RANGE_RST;
      lim_r      <= SHAPE_TOL_RST;
    end else begin
      max_dist_r <= max_dist_nxt;
      lim_r      <= lim_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_RANGE: cfg_prdata = CFG_DATA_W'(max_dist_r);
      REG_SHAPE_TOL: cfg_prdata = CFG_DATA_W'(lim_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg.max_range = max_dist_r;
  assign cfg.shape_tol = lim_r;

endmodule

/* rtl/core/lntf_scan.sv */
// ----------------------------------------------------------------------------
// lntf_scan
// Scan loader: writes each distance into the scan RAM and tracks the first
// angle holding the smallest valid distance.
// ----------------------------------------------------------------------------
module lntf_scan
  import lntf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [DIST_W-1:0]  in_distance,
  input  logic               busy,
  input  cfg_t               cfg,
  output logic               ram_we,
  output logic [ANGLE_W-1:0] ram_waddr,
  output logic [DIST_W-1:0]  ram_wdata,
  output scan_done_t         done
);

  logic [ANGLE_W-1:0] count_r, count_nxt;
  logic [DIST_W-1:0]  min_r, min_nxt;
  logic [ANGLE_W-1:0] min_angle_r, min_angle_nxt;
  logic               min_valid_r, min_valid_nxt;
  logic               accept;
  logic               take_new;
  logic               last_sample;

  assign accept      = in_valid & ~busy;
  assign last_sample = (count_r == ANGLE_W'(SCAN_POINTS - 1));
  assign take_new    = (in_distance != '0) && (in_distance < cfg.max_range) &&
                       (!min_valid_r || (in_distance < min_r));

  assign ram_we    = accept;
  assign ram_waddr = count_r;
  assign ram_wdata = in_distance;

  always_comb begin
    count_nxt     = count_r;
    min_nxt       = min_r;
    min_angle_nxt = min_angle_r;
    min_valid_nxt = min_valid_r;
    if (accept) begin
      if (last_sample) begin
        // scan complete, start over
        count_nxt     = '0;
        min_valid_nxt = 1'b0;
        min_angle_nxt = '0;
      end else begin
        count_nxt = count_r + 1'b1;
        if (take_new) begin
          min_nxt       = in_distance;
          min_angle_nxt = count_r;
          min_valid_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      min_valid_r <= 1'b0;
      min_angle_r <= '0;
    end else begin
      count_r     <= count_nxt;
      min_valid_r <= min_valid_nxt;
      min_angle_r <= min_angle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    min_r <= min_nxt;
  end

  // summary includes the sample arriving with the end of scan
  always_comb begin
    done.start = accept & last_sample;
    done.found = min_valid_r | take_new;
    if (take_new) begin
      done.angle   = count_r;
      done.nearest = in_distance;
    end else if (min_valid_r) begin
      done.angle   = min_angle_r;
      done.nearest = min_r;
    end else begin
      done.angle   = '0;
      done.nearest = cfg.max_range;
    end
  end

endmodule

/* rtl/core/lntf_window.sv */
// ----------------------------------------------------------------------------
// lntf_window
// Window pass: reads the target and its neighbours from the scan RAM, builds
// the shape profile and span angles, then streams out one result per slot.
// ----------------------------------------------------------------------------
module lntf_window
  import lntf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  scan_done_t             done,
  input  cfg_t                   cfg,
  output logic                   busy,
  output logic                   ram_re,
  output logic [ANGLE_W-1:0]     ram_raddr,
  input  logic [DIST_W-1:0]      ram_rdata,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [DIST_W-1:0]      out_shape_distance,
  output logic [ANGLE_OUT_W-1:0] out_target_angle,
  output logic [DIST_W-1:0]      out_nearest_distance,
  output logic [ANGLE_OUT_W-1:0] out_span_low_angle,
  output logic [ANGLE_OUT_W-1:0] out_span_high_angle,
  output logic                   out_found,
  output logic                   out_last
);

  localparam int ISS_W = $clog2(NUM_SLOTS + 2);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [ISS_W-1:0]   iss_r, iss_nxt;
  logic               rv_r;
  logic [ISS_W-1:0]   rtag_r;
  logic [ANGLE_W-1:0] rpos_r;
  logic [SIDX_W-1:0]  em_r, em_nxt;

  logic               found_r;
  logic [ANGLE_W-1:0] a_r, lo_r, hi_r, lo_nxt, hi_nxt;
  logic [DIST_W-1:0]  nearest_r;
  logic [DIST_W-1:0]  centre_r;
  logic [DIST_W-1:0]  prof_r [NUM_SLOTS];

  logic               issue;
  logic [SIDX_W-1:0]  iss_slot;
  logic [ANGLE_W:0]   pos_sum;
  logic [ANGLE_W-1:0] pos;
  logic [SIDX_W-1:0]  proc_slot;
  logic               proc_slot_vld;
  logic [DIST_W-1:0]  diff;
  logic               qual;
  logic [DIST_W-1:0]  shape_val;
  logic               load;

  logic                   out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]      out_slot_r;
  logic [DIST_W-1:0]      out_shape_r;
  logic [ANGLE_OUT_W-1:0] out_angle_r;
  logic [DIST_W-1:0]      out_nearest_r;
  logic [ANGLE_OUT_W-1:0] out_lo_r, out_hi_r;
  logic                   out_found_r, out_last_r;

  assign busy = (state_r != ST_IDLE);

  // ---- read issue: centre first, then slots 0..NUM_SLOTS-1
  assign issue    = (state_r == ST_READ) && (iss_r <= ISS_W'(NUM_SLOTS));
  assign iss_slot = SIDX_W'(iss_r - 1'b1);
  assign pos_sum  = (ANGLE_W+1)'(a_r) + slot_offset(iss_slot);
  assign pos      = (pos_sum >= (ANGLE_W+1)'(SCAN_POINTS)) ?
                    ANGLE_W'(pos_sum - (ANGLE_W+1)'(SCAN_POINTS)) : ANGLE_W'(pos_sum);

  assign ram_re    = issue;
  assign ram_raddr = (iss_r == '0) ? a_r : pos;

  // ---- read return processing
  assign proc_slot_vld = rv_r && (rtag_r != '0);
  assign proc_slot     = SIDX_W'(rtag_r - 1'b1);
  assign diff          = (centre_r > ram_rdata) ? (centre_r - ram_rdata) :
                                                  (ram_rdata - centre_r);
  assign qual          = (diff <= cfg.shape_tol);

  always_comb begin
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    shape_val = '0;
    if (int'(proc_slot) == HALF_WINDOW) begin
      shape_val = nearest_r;
    end else if (found_r && qual) begin
      shape_val = ram_rdata;
      if (int'(proc_slot) > HALF_WINDOW) begin
        hi_nxt = rpos_r;
      end else if (lo_r == a_r) begin
        // slots below the centre run outward to inward
        lo_nxt = rpos_r;
      end
    end
  end

  // ---- emit
  assign load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    iss_nxt   = iss_r;
    em_nxt    = em_r;
    case (state_r)
      ST_IDLE: begin
        if (done.start) begin
          state_nxt = ST_READ;
          iss_nxt   = '0;
        end
      end
      ST_READ: begin
        if (issue) begin
          iss_nxt = iss_r + 1'b1;
        end
        if (proc_slot_vld && (proc_slot == SIDX_W'(NUM_SLOTS - 1))) begin
          state_nxt = ST_EMIT;
          em_nxt    = '0;
        end
      end
      ST_EMIT: begin
        if (load) begin
          em_nxt = em_r + 1'b1;
          if (em_r == SIDX_W'(NUM_SLOTS - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_r       <= '0;
      em_r        <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      em_r        <= em_nxt;
      rv_r        <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rtag_r <= iss_r;
    rpos_r <= ram_raddr;
    if ((state_r == ST_IDLE) && done.start) begin
      found_r   <= done.found;
      a_r       <= done.angle;
      nearest_r <= done.nearest;
      lo_r      <= done.angle;
      hi_r      <= done.angle;
    end else if (proc_slot_vld) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (rv_r && (rtag_r == '0)) begin
      centre_r <= ram_rdata;
    end
    if (proc_slot_vld) begin
      prof_r[proc_slot] <= shape_val;
    end
    if (load) begin
      out_slot_r    <= SLOT_W'(em_r);
      out_shape_r   <= prof_r[em_r];
      out_angle_r   <= ANGLE_OUT_W'(a_r);
      out_nearest_r <= nearest_r;
      out_lo_r      <= ANGLE_OUT_W'(lo_r);
      out_hi_r      <= ANGLE_OUT_W'(hi_r);
      out_found_r   <= found_r;
      out_last_r    <= (em_r == SIDX_W'(NUM_SLOTS - 1));
    end
  end

  assign out_valid            = out_valid_r;
  assign out_slot             = out_slot_r;
  assign out_shape_distance   = out_shape_r;
  assign out_target_angle     = out_angle_r;
  assign out_nearest_distance = out_nearest_r;
  assign out_span_low_angle   = out_lo_r;
  assign out_span_high_angle  = out_hi_r;
  assign out_found            = out_found_r;
  assign out_last             = out_last_r;

  // ---- checks
  a_start_reads: assert property (@(posedge clk) disable iff (!rst_n)
    done.start |=> (state_r == ST_READ))
    else $error("window pass did not start after end of scan");

  a_read_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r |-> ($past(state_r) == ST_READ))
    else $error("ram read returned outside the window pass");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_slot_r == SLOT_W'(NUM_SLOTS - 1)))
    else $error("last flag on wrong slot");

  a_empty_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |->
      ((out_lo_r == out_angle_r) && (out_hi_r == out_angle_r)))
    else $error("span angles moved on an empty scan");

endmodule
